// File: hw/rtl/lpst_pkg.sv
package lpst_pkg;

   localparam int TABLE_SIZE_DEF = 8;

   localparam int LEN_W    = 4;
   localparam int HEAD_W   = 64;
   localparam int TAIL_W   = 8;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_OUT_W = 3;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_INSERTED  = 2'd0;
   localparam status_type ST_FOUND     = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // one stored slot: key and handle side by side in the key ram
   typedef struct packed {
      logic [LEN_W-1:0]    key_length;
      logic [HEAD_W-1:0]   key_head;
      logic [TAIL_W-1:0]   key_tail;
      logic [HANDLE_W-1:0] handle;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // microprogram addresses
   typedef logic [3:0] upc_type;

   localparam upc_type UP_IDLE        = 4'd0;
   localparam upc_type UP_DISPATCH    = 4'd1;
   localparam upc_type UP_INS_CHECK   = 4'd2;
   localparam upc_type UP_INS_PROBE   = 4'd3;
   localparam upc_type UP_LOOK_PROBE  = 4'd4;
   localparam upc_type UP_LOOK_END    = 4'd5;
   localparam upc_type UP_EMIT_FULL   = 4'd6;
   localparam upc_type UP_EMIT_INSERT = 4'd7;
   localparam upc_type UP_EMIT_FOUND  = 4'd8;
   localparam upc_type UP_EMIT_MISS   = 4'd9;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ_VALID,
      COND_IS_LOOKUP,
      COND_TABLE_FULL,
      COND_SLOT_FREE,
      COND_LOOK_STOP,
      COND_KEY_HIT,
      COND_OUT_FREE
   } cond_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_ADVANCE,
      ACT_EMIT,
      ACT_STORE_EMIT
   } act_type;

   typedef struct packed {
      cond_type   cond;
      upc_type    jump_t;
      upc_type    jump_f;
      act_type    act_t;
      act_type    act_f;
      status_type status;
      logic       ready;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic is_lookup;
      logic table_full;
      logic slot_free;
      logic look_stop;
      logic key_hit;
      logic out_free;
   } flags_type;

   // sequencer commands to the datapath
   typedef struct packed {
      act_type    act;
      status_type status;
      logic       ready;
   } ctrl_type;

   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      w = '{cond: COND_ALWAYS, jump_t: UP_IDLE, jump_f: UP_IDLE, act_t: ACT_NONE,
            act_f: ACT_NONE, status: ST_INSERTED, ready: 1'b0};
      case (upc)
         UP_IDLE: begin
            w.cond   = COND_REQ_VALID;
            w.jump_t = UP_DISPATCH;
            w.jump_f = UP_IDLE;
            w.act_t  = ACT_LOAD;
            w.ready  = 1'b1;
         end
         UP_DISPATCH: begin
            w.cond   = COND_IS_LOOKUP;
            w.jump_t = UP_LOOK_PROBE;
            w.jump_f = UP_INS_CHECK;
         end
         UP_INS_CHECK: begin
            w.cond   = COND_TABLE_FULL;
            w.jump_t = UP_EMIT_FULL;
            w.jump_f = UP_INS_PROBE;
         end
         UP_INS_PROBE: begin
            w.cond   = COND_SLOT_FREE;
            w.jump_t = UP_EMIT_INSERT;
            w.jump_f = UP_INS_PROBE;
            w.act_f  = ACT_ADVANCE;
         end
         UP_LOOK_PROBE: begin
            w.cond   = COND_LOOK_STOP;
            w.jump_t = UP_LOOK_END;
            w.jump_f = UP_LOOK_PROBE;
            w.act_f  = ACT_ADVANCE;
         end
         UP_LOOK_END: begin
            w.cond   = COND_KEY_HIT;
            w.jump_t = UP_EMIT_FOUND;
            w.jump_f = UP_EMIT_MISS;
         end
         UP_EMIT_FULL: begin
            w.cond   = COND_OUT_FREE;
            w.jump_t = UP_IDLE;
            w.jump_f = UP_EMIT_FULL;
            w.act_t  = ACT_EMIT;
            w.status = ST_FULL;
         end
         UP_EMIT_INSERT: begin
            w.cond   = COND_OUT_FREE;
            w.jump_t = UP_IDLE;
            w.jump_f = UP_EMIT_INSERT;
            w.act_t  = ACT_STORE_EMIT;
            w.status = ST_INSERTED;
         end
         UP_EMIT_FOUND: begin
            w.cond   = COND_OUT_FREE;
            w.jump_t = UP_IDLE;
            w.jump_f = UP_EMIT_FOUND;
            w.act_t  = ACT_EMIT;
            w.status = ST_FOUND;
         end
         UP_EMIT_MISS: begin
            w.cond   = COND_OUT_FREE;
            w.jump_t = UP_IDLE;
            w.jump_f = UP_EMIT_MISS;
            w.act_t  = ACT_EMIT;
            w.status = ST_NOT_FOUND;
         end
         default: begin
            w.jump_t = UP_IDLE;
            w.jump_f = UP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/lpst_if.sv
interface lpst_req_if import lpst_pkg::*;;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [LEN_W-1:0]    key_length;
   logic [HEAD_W-1:0]   key_head;
   logic [TAIL_W-1:0]   key_tail;
   logic [HANDLE_W-1:0] entry_handle;

   modport source (output valid, operation, key_length, key_head, key_tail, entry_handle,
                   input ready);
   modport sink (input valid, operation, key_length, key_head, key_tail, entry_handle,
                 output ready);
endinterface

interface lpst_rsp_if import lpst_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [HANDLE_W-1:0]   found_handle;
   logic [SLOT_OUT_W-1:0] slot_index;

   modport source (output valid, status, found_handle, slot_index, input ready);
   modport sink (input valid, status, found_handle, slot_index, output ready);
endinterface

// File: hw/rtl/linear_probe_string_table_core.sv
// Open-addressing table of short keys (length, eight head bytes, one tail byte) each stored
// with a 16-bit handle. A request either inserts a key at the first free slot found by
// probing forward from slot key_length mod TABLE_SIZE, or looks a key up along the same
// path, stopping at a free slot, a matching key or after TABLE_SIZE probes. Duplicates are
// stored again and an insert into a full table reports full; every request gives exactly
// one response. A small microprogram steps a probe loop that visits one slot per cycle
// through the key ram's read port; an insert into a full table skips the loop. One
// request is handled at a time. The response sits in an output register, so the next
// request is taken while a response waits. No clearing pass is needed after reset.
module linear_probe_string_table_core import lpst_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lpst_req_if.sink   req_ch,
   lpst_rsp_if.source rsp_ch
);

   flags_type flags;
   ctrl_type  ctrl;

   lpst_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   lpst_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .ctrl   (ctrl),
      .flags  (flags)
   );

endmodule

// File: hw/rtl/lpst_ram.sv
module lpst_ram import lpst_pkg::*; #(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = TABLE_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lpst_seq.sv
module lpst_seq import lpst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   upc_type   upc_ff;
   upc_type   upc_in;
   ucode_type word;
   logic      take;

   assign word = ucode_rom(upc_ff);

   always_comb begin
      case (word.cond)
         COND_ALWAYS:     take = 1'b1;
         COND_REQ_VALID:  take = flags.req_valid;
         COND_IS_LOOKUP:  take = flags.is_lookup;
         COND_TABLE_FULL: take = flags.table_full;
         COND_SLOT_FREE:  take = flags.slot_free;
         COND_LOOK_STOP:  take = flags.look_stop;
         COND_KEY_HIT:    take = flags.key_hit;
         COND_OUT_FREE:   take = flags.out_free;
         default:         take = 1'b1;
      endcase
   end

   assign upc_in      = take ? word.jump_t : word.jump_f;
   assign ctrl.act    = take ? word.act_t : word.act_f;
   assign ctrl.status = word.status;
   assign ctrl.ready  = word.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: hw/rtl/lpst_datapath.sv
module lpst_datapath import lpst_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lpst_req_if.sink   req_ch,
   lpst_rsp_if.source rsp_ch,
   input  ctrl_type   ctrl,
   output flags_type  flags
);

   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int LEN_VALUES = 2 ** LEN_W;

   logic [SLOT_W-1:0] home_lut [LEN_VALUES];

   // home slot for each possible length, worked out at elaboration
   for (genvar i = 0; i < LEN_VALUES; i++) begin : g_home
      assign home_lut[i] = SLOT_W'(i % TABLE_SIZE);
   end

   logic                  op_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [HEAD_W-1:0]     head_ff;
   logic [TAIL_W-1:0]     tail_ff;
   logic [HANDLE_W-1:0]   hdl_ff;
   logic [SLOT_W-1:0]     pos_ff, pos_in;
   logic [SLOT_W-1:0]     probe_ff, probe_in;
   logic [TABLE_SIZE-1:0] used_ff, used_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [HANDLE_W-1:0]   rsp_handle_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;

   slot_entry_type wr_entry;
   slot_entry_type rd_entry;
   logic [ENTRY_W-1:0] rd_bits;
   logic store;
   logic emit;
   logic load;
   logic key_match;
   logic last_probe;
   logic slot_used;

   assign load  = (ctrl.act == ACT_LOAD);
   assign store = (ctrl.act == ACT_STORE_EMIT);
   assign emit  = (ctrl.act == ACT_EMIT) || store;

   always_comb begin
      pos_in   = pos_ff;
      probe_in = probe_ff;
      if (load) begin
         pos_in   = home_lut[req_ch.key_length];
         probe_in = '0;
      end else if (ctrl.act == ACT_ADVANCE) begin
         pos_in   = (pos_ff == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_ff + 1'b1;
         probe_in = probe_ff + 1'b1;
      end
   end

   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      if (store) begin
         used_in[pos_ff] = 1'b1;
         count_in        = count_ff + 1'b1;
      end
   end

   assign wr_entry = '{key_length: len_ff, key_head: head_ff, key_tail: tail_ff,
                       handle: hdl_ff};

   // read address follows the next probe slot so the data lines up with pos_ff
   lpst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (pos_ff),
      .wr_data (wr_entry),
      .rd_addr (pos_in),
      .rd_data (rd_bits)
   );

   assign rd_entry = rd_bits;

   assign slot_used  = used_ff[pos_ff];
   assign key_match  = (rd_entry.key_length == len_ff) && (rd_entry.key_head == head_ff) &&
                       (rd_entry.key_tail == tail_ff);
   assign last_probe = (probe_ff == SLOT_W'(TABLE_SIZE - 1));

   assign flags.req_valid  = req_ch.valid;
   assign flags.is_lookup  = (op_ff == OP_LOOKUP);
   assign flags.table_full = (count_ff == CNT_W'(TABLE_SIZE));
   assign flags.slot_free  = !slot_used;
   assign flags.look_stop  = !slot_used || key_match || last_probe;
   assign flags.key_hit    = slot_used && key_match;
   assign flags.out_free   = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      probe_ff <= probe_in;
      if (load) begin
         op_ff   <= req_ch.operation;
         len_ff  <= req_ch.key_length;
         head_ff <= req_ch.key_head;
         tail_ff <= req_ch.key_tail;
         hdl_ff  <= req_ch.entry_handle;
      end
      if (emit) begin
         rsp_status_ff <= ctrl.status;
         rsp_handle_ff <= (ctrl.status == ST_FOUND) ? rd_entry.handle : '0;
         rsp_slot_ff   <= (ctrl.status == ST_FOUND || ctrl.status == ST_INSERTED) ?
                          SLOT_OUT_W'(pos_ff) : '0;
      end
   end

   assign req_ch.ready        = ctrl.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.found_handle = rsp_handle_ff;
   assign rsp_ch.slot_index   = rsp_slot_ff;

endmodule

// File: hw/rtl/lpst_checker.sv
module lpst_checker import lpst_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [HANDLE_W-1:0]   rsp_handle,
   input logic [SLOT_OUT_W-1:0] rsp_slot
);

   // one request at a time: no second accept straight after one
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // misses and full reports carry no handle and no slot
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)
      |-> rsp_handle == '0 && rsp_slot == '0)
      else $error("miss or full response with non-zero fields");

   a_insert_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |-> rsp_handle == '0)
      else $error("insert response with a handle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_handle) && $stable(rsp_slot))
      else $error("stalled response changed");

endmodule

bind linear_probe_string_table_core lpst_checker u_lpst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_handle (rsp_ch.found_handle),
   .rsp_slot   (rsp_ch.slot_index)
);

// File: verif/linear_probe_string_table_core_tb.sv
module linear_probe_string_table_core_tb;
   import lpst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = TABLE_SIZE_DEF;
   localparam int RANDOM_REQS = 750;
   localparam int HOLD_AT     = 1200;
   localparam int HOLD_LEN    = 300;
   localparam int CALM_FROM   = 3000;
   localparam int CALM_TO     = 4500;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic                operation;
      logic [LEN_W-1:0]    key_length;
      logic [HEAD_W-1:0]   key_head;
      logic [TAIL_W-1:0]   key_tail;
      logic [HANDLE_W-1:0] entry_handle;
      logic                drain_first;
   } probe_request_type;

   typedef struct {
      status_type            status;
      logic [HANDLE_W-1:0]   found_handle;
      logic [SLOT_OUT_W-1:0] slot_index;
   } probe_response_type;

   logic clock;
   logic reset;

   lpst_req_if req_if ();
   lpst_rsp_if rsp_if ();

   linear_probe_string_table_core #(.TABLE_SIZE(SLOTS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // shadow copy of the table contents
   logic                shadow_used   [SLOTS];
   logic [LEN_W-1:0]    shadow_length [SLOTS];
   logic [HEAD_W-1:0]   shadow_head   [SLOTS];
   logic [TAIL_W-1:0]   shadow_tail   [SLOTS];
   logic [HANDLE_W-1:0] shadow_handle [SLOTS];

   probe_request_type  pending_requests[$];
   probe_request_type  inserted_keys[$];
   probe_response_type awaited_responses[$];
   probe_request_type  driven_req;

   int  fail_count = 0;
   int  cycle_count;
   int  hold_left;
   logic calm;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   always begin
      clock = 1'b0;
      #5ns;
      clock = 1'b1;
      #5ns;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at cycle %0d", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   function automatic void predict_response(input probe_request_type r);
      probe_response_type resp;
      int   pos;
      logic done;
      resp = '{status: ST_NOT_FOUND, found_handle: '0, slot_index: '0};
      pos  = r.key_length % SLOTS;
      done = 1'b0;
      if (r.operation == OP_INSERT) begin
         resp.status = ST_FULL;
         for (int n = 0; n < SLOTS && !done; n++) begin
            if (!shadow_used[pos]) begin
               shadow_used[pos]   = 1'b1;
               shadow_length[pos] = r.key_length;
               shadow_head[pos]   = r.key_head;
               shadow_tail[pos]   = r.key_tail;
               shadow_handle[pos] = r.entry_handle;
               resp.status        = ST_INSERTED;
               resp.slot_index    = pos[SLOT_OUT_W-1:0];
               done               = 1'b1;
            end else begin
               pos = (pos + 1) % SLOTS;
            end
         end
      end else begin
         for (int n = 0; n < SLOTS && !done; n++) begin
            if (!shadow_used[pos]) begin
               done = 1'b1;
            end else if (shadow_length[pos] == r.key_length && shadow_head[pos] == r.key_head
                         && shadow_tail[pos] == r.key_tail) begin
               resp.status       = ST_FOUND;
               resp.found_handle = shadow_handle[pos];
               resp.slot_index   = pos[SLOT_OUT_W-1:0];
               done              = 1'b1;
            end else begin
               pos = (pos + 1) % SLOTS;
            end
         end
      end
      awaited_responses.push_back(resp);
   endfunction

   task automatic queue_request(input logic op, input logic [LEN_W-1:0] len,
                                input logic [HEAD_W-1:0] head, input logic [TAIL_W-1:0] tail,
                                input logic [HANDLE_W-1:0] handle, input logic drain);
      probe_request_type r;
      r = '{operation: op, key_length: len, key_head: head, key_tail: tail,
            entry_handle: handle, drain_first: drain};
      pending_requests.push_back(r);
      if (op == OP_INSERT) inserted_keys.push_back(r);
   endtask

   // random key: either zero padded to its length or raw bits with any length
   function automatic probe_request_type random_key();
      probe_request_type r;
      int len;
      r.operation    = OP_LOOKUP;
      r.drain_first  = 1'b0;
      r.entry_handle = HANDLE_W'($urandom_range(0, 65535));
      r.key_head     = {$urandom, $urandom};
      r.key_tail     = TAIL_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
         len          = $urandom_range(0, 9);
         r.key_length = LEN_W'(len);
         if (len < 8) r.key_head = r.key_head & ((64'd1 << (8 * len)) - 64'd1);
         if (len < 9) r.key_tail = '0;
      end else begin
         r.key_length = LEN_W'($urandom_range(0, 15));
      end
      return r;
   endfunction

   initial begin : stimulus
      probe_request_type r;
      int pick;
      int bit_sel;
      int roll;

      reset = 1'b1;

      // empty table, then collisions, wrap-around and duplicates
      queue_request(OP_LOOKUP, 4'd0, 64'h0, 8'h00, 16'h0000, 1'b0);
      queue_request(OP_INSERT, 4'd7, 64'h00FF_FFFF_FFFF_FFFF, 8'h00, 16'hFFFF, 1'b0);
      queue_request(OP_INSERT, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h1234, 1'b0);
      queue_request(OP_LOOKUP, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0);
      queue_request(OP_INSERT, 4'd7, 64'h00FF_FFFF_FFFF_FFFF, 8'h00, 16'h0000, 1'b0);
      queue_request(OP_LOOKUP, 4'd7, 64'h00FF_FFFF_FFFF_FFFF, 8'h00, 16'h0000, 1'b0);
      queue_request(OP_LOOKUP, 4'd7, 64'h00FF_FFFF_FFFF_FFFF, 8'h01, 16'h0000, 1'b0);
      queue_request(OP_INSERT, 4'd0, 64'h0, 8'h00, 16'h8000, 1'b0);
      queue_request(OP_INSERT, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h00FF, 1'b0);
      queue_request(OP_LOOKUP, 4'd9, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0000, 1'b0);
      queue_request(OP_LOOKUP, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0000, 1'b0);
      queue_request(OP_INSERT, 4'd4, 64'h0000_0000_6B65_7973, 8'h00, 16'h5555, 1'b0);
      queue_request(OP_INSERT, 4'd13, 64'h8000_0000_0000_0001, 8'h80, 16'hAAAA, 1'b0);
      queue_request(OP_INSERT, 4'd2, 64'h0000_0000_0000_6869, 8'h00, 16'h0001, 1'b0);
      // table now full
      queue_request(OP_INSERT, 4'd1, 64'h0000_0000_0000_0041, 8'h00, 16'h7777, 1'b0);
      queue_request(OP_LOOKUP, 4'd8, 64'h0123_4567_89AB_CDEF, 8'h55, 16'h0000, 1'b0);
      queue_request(OP_LOOKUP, 4'd2, 64'h0000_0000_0000_6869, 8'h00, 16'h0000, 1'b0);
      queue_request(OP_LOOKUP, 4'd0, 64'h0, 8'h00, 16'hFFFF, 1'b0);
      queue_request(OP_LOOKUP, 4'd13, 64'h8000_0000_0000_0001, 8'h80, 16'h0000, 1'b0);
      queue_request(OP_LOOKUP, 4'd4, 64'h0000_0000_6B65_7973, 8'h00, 16'h0000, 1'b1);

      for (int i = 0; i < RANDOM_REQS; i++) begin
         r    = random_key();
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 30) begin
            r.operation = OP_INSERT;
         end else if (roll < 70) begin
            pick           = $urandom_range(0, inserted_keys.size() - 1);
            r.key_length   = inserted_keys[pick].key_length;
            r.key_head     = inserted_keys[pick].key_head;
            r.key_tail     = inserted_keys[pick].key_tail;
         end else if (roll < 85) begin
            // near miss: one key bit flipped
            pick         = $urandom_range(0, inserted_keys.size() - 1);
            r.key_length = inserted_keys[pick].key_length;
            r.key_head   = inserted_keys[pick].key_head;
            r.key_tail   = inserted_keys[pick].key_tail;
            bit_sel      = $urandom_range(0, LEN_W + HEAD_W + TAIL_W - 1);
            if (bit_sel < HEAD_W) r.key_head[bit_sel] = ~r.key_head[bit_sel];
            else if (bit_sel < HEAD_W + TAIL_W) r.key_tail[bit_sel - HEAD_W] =
                                                   ~r.key_tail[bit_sel - HEAD_W];
            else r.key_length[bit_sel - HEAD_W - TAIL_W] =
                    ~r.key_length[bit_sel - HEAD_W - TAIL_W];
         end
         r.drain_first = (i == RANDOM_REQS / 2);
         queue_request(r.operation, r.key_length, r.key_head, r.key_tail, r.entry_handle,
                       r.drain_first);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_if.valid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (2 * (SLOTS + 4)) @(posedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         foreach (shadow_used[s]) shadow_used[s] = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_response(driven_req);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 24) &&
                !(pending_requests[0].drain_first && awaited_responses.size() != 0)) begin
               driven_req = pending_requests.pop_front();
               req_if.valid        <= 1'b1;
               req_if.operation    <= driven_req.operation;
               req_if.key_length   <= driven_req.key_length;
               req_if.key_head     <= driven_req.key_head;
               req_if.key_tail     <= driven_req.key_tail;
               req_if.entry_handle <= driven_req.entry_handle;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_responses.size() == 0) begin
               report_mismatch("unexpected response, status", 32'(rsp_if.status), '0);
            end else begin
               if (rsp_if.status !== awaited_responses[0].status)
                  report_mismatch("status", 32'(rsp_if.status),
                                  32'(awaited_responses[0].status));
               if (rsp_if.found_handle !== awaited_responses[0].found_handle)
                  report_mismatch("found_handle", 32'(rsp_if.found_handle),
                                  32'(awaited_responses[0].found_handle));
               if (rsp_if.slot_index !== awaited_responses[0].slot_index)
                  report_mismatch("slot_index", 32'(rsp_if.slot_index),
                                  32'(awaited_responses[0].slot_index));
               void'(awaited_responses.pop_front());
            end
         end
         rsp_if.ready <= (hold_left != 0) ? 1'b0 : (calm || $urandom_range(0, 99) >= 24);
      end
   end

   // cycle count, long receiver hold-off and run limit
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
         hold_left   <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count == HOLD_AT) hold_left <= HOLD_LEN;
         else if (hold_left != 0) hold_left <= hold_left - 1;
         if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
